### rtl/windowed_local_minimum_finder_assert.svh
// Assertion helpers for windowed_local_minimum_finder.sv.
`ifndef WINDOWED_LOCAL_MINIMUM_FINDER_ASSERT_SVH
`define WINDOWED_LOCAL_MINIMUM_FINDER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define WLMF_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define WLMF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/wlmf_pkg.sv
package wlmf_pkg;

    localparam int MAX_SPAN_DEF      = 7;
    localparam int SAMPLE_BITS_DEF   = 30;
    localparam int POSITION_BITS_DEF = 20;

    localparam int SPAN_BITS      = 3;
    localparam int CFG_INDEX_BITS = 2;

    typedef logic [CFG_INDEX_BITS-1:0] t_cfg_index;

    localparam t_cfg_index CFG_BEFORE_SPAN = 2'd0;
    localparam t_cfg_index CFG_AFTER_SPAN  = 2'd1;

    typedef struct packed {
        logic shift;
        logic clear;
    } t_cell_ctl;

endpackage

### rtl/wlmf_cell.sv
module wlmf_cell #(
    parameter int SAMPLE_BITS = wlmf_pkg::SAMPLE_BITS_DEF,
    parameter int MAX_SPAN    = wlmf_pkg::MAX_SPAN_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  wlmf_pkg::t_cell_ctl    i_ctl,
    input  logic [SAMPLE_BITS-1:0] i_new_sample,
    input  logic [SAMPLE_BITS-1:0] i_prev_value,
    input  logic                   i_prev_valid,
    input  logic                   i_prev_later,
    input  logic [MAX_SPAN-1:0]    i_prev_earlier,
    output logic [SAMPLE_BITS-1:0] o_value,
    output logic                   o_valid,
    output logic                   o_later,
    output logic [MAX_SPAN-1:0]    o_earlier,
    output logic                   o_lt_new
);
    import wlmf_pkg::*;

    logic [SAMPLE_BITS-1:0] r_value;
    logic                   r_valid;
    logic                   r_later;
    logic [MAX_SPAN-1:0]    r_earlier;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clear) begin
            r_valid <= 1'b0;
        end else if (i_ctl.shift) begin
            r_valid <= i_prev_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_value   <= i_prev_value;
            r_later   <= i_prev_later;
            r_earlier <= i_prev_earlier;
        end
    end

    // later flag: some newer sample was smaller than this one
    assign o_value   = r_value;
    assign o_valid   = r_valid;
    assign o_later   = r_later | (r_valid && (i_new_sample < r_value));
    assign o_earlier = r_earlier;
    assign o_lt_new  = r_valid && (r_value < i_new_sample);

endmodule

### rtl/windowed_local_minimum_finder.sv
// Finds the first sample of a run that is not above any of the previous
// before_span or the next after_span samples (windows cut short at the run
// edges, ties allowed) and returns its 1-based position, saturating. Takes
// one sample per cycle with no bubbles; o_out_valid rises in the cycle after
// the deciding sample is taken. The deciding sample is the one after_span
// samples later, or the last sample, where the earliest pending candidate
// wins. A row of MAX_SPAN+1 cells holds the recent samples; each cell
// compares against the incoming sample every cycle. After a result the rest
// of the run is ignored; the block clears on the last sample. Runs with no
// qualifying sample give no result. Spans are clamped to MAX_SPAN. Input
// stalls only while a result waits on the output.
`include "windowed_local_minimum_finder_assert.svh"

module windowed_local_minimum_finder #(
    parameter int MAX_SPAN      = wlmf_pkg::MAX_SPAN_DEF,
    parameter int SAMPLE_BITS   = wlmf_pkg::SAMPLE_BITS_DEF,
    parameter int POSITION_BITS = wlmf_pkg::POSITION_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  wlmf_pkg::t_cfg_index           i_cfg_index,
    input  logic [wlmf_pkg::SPAN_BITS-1:0] i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [SAMPLE_BITS-1:0]         i_sample,
    input  logic                           i_last,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [POSITION_BITS-1:0]       o_position
);
    import wlmf_pkg::*;

    localparam int IDX_BITS = (MAX_SPAN < 2) ? 1 : $clog2(MAX_SPAN + 1);
    localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};

    logic [SPAN_BITS-1:0]     r_before;
    logic [SPAN_BITS-1:0]     r_after;
    logic [POSITION_BITS-1:0] r_count;
    logic [POSITION_BITS-1:0] n_count;
    logic                     r_found;
    logic                     r_out_valid;
    logic [POSITION_BITS-1:0] r_pos;
    logic [POSITION_BITS-1:0] n_pos;

    logic       in_xfer;
    t_cell_ctl  cell_ctl;

    // inputs of cell k = its contents after a shift
    logic [SAMPLE_BITS-1:0] w_val [MAX_SPAN+1];
    logic [MAX_SPAN:0]      w_vld;
    logic [MAX_SPAN:0]      w_lat;
    logic [MAX_SPAN-1:0]    w_ear [MAX_SPAN+1];
    logic [MAX_SPAN-1:0]    w_lt;

    logic [IDX_BITS-1:0] a_eff;
    logic [IDX_BITS-1:0] b_eff;
    logic [MAX_SPAN-1:0] b_mask;
    logic [MAX_SPAN:0]   qual;
    logic                hit;
    logic [IDX_BITS-1:0] sel;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign in_xfer     = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_position  = r_pos;

    assign cell_ctl.shift = in_xfer && !r_found;
    assign cell_ctl.clear = in_xfer && i_last;

    assign w_val[0] = i_sample;
    assign w_vld[0] = 1'b1;
    assign w_lat[0] = 1'b0;
    assign w_ear[0] = w_lt;

    for (genvar k = 0; k <= MAX_SPAN; k++) begin : g_cell
        if (k < MAX_SPAN) begin : g_mid
            wlmf_cell #(
                .SAMPLE_BITS(SAMPLE_BITS),
                .MAX_SPAN   (MAX_SPAN)
            ) u_cell (
                .i_clk         (i_clk),
                .i_rst_n       (i_rst_n),
                .i_ctl         (cell_ctl),
                .i_new_sample  (i_sample),
                .i_prev_value  (w_val[k]),
                .i_prev_valid  (w_vld[k]),
                .i_prev_later  (w_lat[k]),
                .i_prev_earlier(w_ear[k]),
                .o_value       (w_val[k+1]),
                .o_valid       (w_vld[k+1]),
                .o_later       (w_lat[k+1]),
                .o_earlier     (w_ear[k+1]),
                .o_lt_new      (w_lt[k])
            );
        end else begin : g_tail
            wlmf_cell #(
                .SAMPLE_BITS(SAMPLE_BITS),
                .MAX_SPAN   (MAX_SPAN)
            ) u_cell (
                .i_clk         (i_clk),
                .i_rst_n       (i_rst_n),
                .i_ctl         (cell_ctl),
                .i_new_sample  (i_sample),
                .i_prev_value  (w_val[k]),
                .i_prev_valid  (w_vld[k]),
                .i_prev_later  (w_lat[k]),
                .i_prev_earlier(w_ear[k]),
                .o_value       (),
                .o_valid       (),
                .o_later       (),
                .o_earlier     (),
                .o_lt_new      ()
            );
        end
    end

    always_comb begin
        a_eff = (r_after > MAX_SPAN) ? IDX_BITS'(MAX_SPAN) : IDX_BITS'(r_after);
        b_eff = (r_before > MAX_SPAN) ? IDX_BITS'(MAX_SPAN) : IDX_BITS'(r_before);
        for (int d = 1; d <= MAX_SPAN; d++) begin
            b_mask[d-1] = (d <= b_eff);
        end
        for (int o = 0; o <= MAX_SPAN; o++) begin
            qual[o] = w_vld[o] && !w_lat[o] && !(|(w_ear[o] & b_mask));
        end
        // largest slot wins: it is the earliest sample
        hit = 1'b0;
        sel = '0;
        for (int o = 0; o <= MAX_SPAN; o++) begin
            if (o <= a_eff && qual[o] && (i_last || o == a_eff)) begin
                hit = 1'b1;
                sel = IDX_BITS'(o);
            end
        end
        n_count = (r_count == POS_MAX) ? r_count : r_count + 1'b1;
        n_pos   = (n_count == POS_MAX) ? POS_MAX : n_count - POSITION_BITS'(sel);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_before <= '0;
            r_after  <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_BEFORE_SPAN: r_before <= i_cfg_data;
                CFG_AFTER_SPAN:  r_after  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_found <= 1'b0;
        end else if (in_xfer) begin
            if (i_last) begin
                r_count <= '0;
                r_found <= 1'b0;
            end else if (!r_found) begin
                r_count <= n_count;
                r_found <= hit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (cell_ctl.shift && hit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (cell_ctl.shift && hit) begin
            r_pos <= n_pos;
        end
    end

    `WLMF_ASSERT_NEXT(a_found_after_hit, i_clk, i_rst_n,
        cell_ctl.shift && hit && !i_last, r_found, "result not latched as found")
    `WLMF_ASSERT_NEXT(a_clear_on_last, i_clk, i_rst_n,
        in_xfer && i_last, !r_found && r_count == '0, "run not cleared on last")
    `WLMF_ASSERT_SAME(a_found_has_count, i_clk, i_rst_n,
        r_found, r_count != '0, "found set with empty run")
    `WLMF_ASSERT_SAME(a_pos_nonzero, i_clk, i_rst_n,
        r_out_valid, r_pos != '0, "position zero")

endmodule

### tb/tb.sv
module tb;
    import wlmf_pkg::*;

    localparam int SW          = SAMPLE_BITS_DEF;
    localparam int PW          = POSITION_BITS_DEF;
    localparam int DEPTH       = 2 * MAX_SPAN_DEF + 1;
    localparam int QUIET_LIMIT = 2000;
    localparam int LONG_HOLD   = 400;
    localparam int LONG_RUN    = 120;
    localparam int RANDOM_SAMPLES = 1550;

    localparam logic [SW-1:0] SAMPLE_MAX = '1;
    localparam logic [PW-1:0] POS_MAX    = '1;
    localparam t_cfg_index    CFG_UNUSED = 2'd3;

    typedef enum int {
        SHAPE_RANDOM,
        SHAPE_NARROW,
        SHAPE_FALLING,
        SHAPE_RISING,
        SHAPE_VALLEY
    } t_run_shape;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    t_cfg_index           i_cfg_index;
    logic [SPAN_BITS-1:0] i_cfg_data;
    logic                 i_in_valid;
    logic                 o_in_ready;
    logic [SW-1:0]        i_sample;
    logic                 i_last;
    logic                 o_out_valid;
    logic                 i_out_ready;
    logic [PW-1:0]        o_position;

    windowed_local_minimum_finder dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sample   (i_sample),
        .i_last     (i_last),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_position (o_position)
    );

    // predictor state
    logic [SW-1:0]        run_history [DEPTH];
    logic [DEPTH-1:0]     run_history_valid;
    logic [PW-1:0]        run_count;
    bit                   run_resolved;
    logic [SPAN_BITS-1:0] span_before;
    logic [SPAN_BITS-1:0] span_after;

    logic [PW-1:0] expected_positions [$];

    int  fail_count;
    int  samples_sent;
    int  live_samples;
    int  runs_sent;
    int  positions_checked;
    int  quiet_cycles;
    int  hold_request;
    bit  idle_on;

    initial begin
        i_clk = 1'b0;
    end

    always begin
        #5 i_clk = ~i_clk;
    end

    function automatic void clear_run();
        foreach (run_history[k]) begin
            run_history[k] = '0;
        end
        run_history_valid = '0;
        run_count = '0;
        run_resolved = 1'b0;
    endfunction

    function automatic bit fits_window(input int o, input int b);
        logic [SW-1:0] v;
        v = run_history[o];
        for (int k = 0; k < o; k++) begin
            if (run_history_valid[k] && run_history[k] < v) begin
                return 1'b0;
            end
        end
        for (int k = o + 1; k <= o + b; k++) begin
            if (run_history_valid[k] && run_history[k] < v) begin
                return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    function automatic bit predict_position(input logic [SW-1:0] s, input logic l,
                                            output logic [PW-1:0] pos);
        int a;
        int b;
        a = (span_after > MAX_SPAN_DEF) ? MAX_SPAN_DEF : span_after;
        b = (span_before > MAX_SPAN_DEF) ? MAX_SPAN_DEF : span_before;
        pos = '0;
        if (run_resolved) begin
            if (l) begin
                clear_run();
            end
            return 1'b0;
        end
        live_samples++;
        for (int k = DEPTH - 1; k > 0; k--) begin
            run_history[k] = run_history[k-1];
        end
        run_history[0] = s;
        run_history_valid = {run_history_valid[DEPTH-2:0], 1'b1};
        if (run_count != POS_MAX) begin
            run_count++;
        end
        for (int o = a; o >= 0; o--) begin
            if (run_history_valid[o] && fits_window(o, b)) begin
                pos = (run_count == POS_MAX) ? POS_MAX : PW'(run_count - o);
                if (l) begin
                    clear_run();
                end else begin
                    run_resolved = 1'b1;
                end
                return 1'b1;
            end
            if (!l) begin
                break;
            end
        end
        if (l) begin
            clear_run();
        end
        return 1'b0;
    endfunction

    // checks results, tracks config and input transfers, feeds the watchdog
    always @(posedge i_clk) begin : channel_monitor
        logic [PW-1:0] want_pos;
        if (!i_rst_n) begin
            quiet_cycles = 0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (expected_positions.size() == 0) begin
                    $error("position: expected none, got %0d", o_position);
                    fail_count++;
                end else begin
                    want_pos = expected_positions.pop_front();
                    if (o_position !== want_pos) begin
                        $error("position: expected %0d, got %0d", want_pos, o_position);
                        fail_count++;
                    end
                    positions_checked++;
                end
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_BEFORE_SPAN: span_before = i_cfg_data;
                    CFG_AFTER_SPAN:  span_after  = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && o_in_ready) begin
                samples_sent++;
                if (i_last) begin
                    runs_sent++;
                end
                if (predict_position(i_sample, i_last, want_pos)) begin
                    expected_positions = {expected_positions, want_pos};
                end
            end
            if ((o_out_valid && i_out_ready) || (i_cfg_valid && o_cfg_ready) ||
                (i_in_valid && o_in_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
    end

    initial begin : watchdog
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("timeout: no transfer for %0d cycles", QUIET_LIMIT);
        $display("== FAIL ==");
        $finish;
    end

    // result side: random stall per result while idle_on, plus one long hold on request
    initial begin : out_ready_driver
        int stall;
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            stall = idle_on ? $urandom_range(0, 19) : 0;
            if (hold_request > 0) begin
                stall = hold_request;
                hold_request = 0;
            end
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!(o_out_valid && i_rst_n));
        end
    end

    task automatic send_sample(input logic [SW-1:0] s, input logic l);
        int gap;
        gap = idle_on ? $urandom_range(0, 19) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_sample   <= s;
        i_last     <= l;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic settle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (expected_positions.size() != 0) @(posedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_span(input t_cfg_index idx, input logic [SPAN_BITS-1:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [SPAN_BITS-1:0] pick_span();
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return '1;
            default: return SPAN_BITS'($urandom_range(0, MAX_SPAN_DEF));
        endcase
    endfunction

    task automatic send_run(input int len, input t_run_shape shape);
        logic [SW-1:0] level;
        logic [SW-1:0] s;
        int            step;
        int            pivot;
        bit            falling;
        level = SW'($urandom);
        pivot = $urandom_range(0, len - 1);
        for (int n = 0; n < len; n++) begin
            step = $urandom_range(0, 3);
            falling = (shape == SHAPE_FALLING) || (shape == SHAPE_VALLEY && n < pivot);
            case (shape)
                SHAPE_NARROW: s = SW'($urandom_range(0, 3));
                SHAPE_FALLING, SHAPE_RISING, SHAPE_VALLEY: begin
                    if (falling) begin
                        level = (level > step) ? SW'(level - step) : '0;
                    end else begin
                        level = (level < SAMPLE_MAX - step) ? SW'(level + step) : SAMPLE_MAX;
                    end
                    s = level;
                end
                default: s = SW'($urandom);
            endcase
            send_sample(s, n == len - 1);
        end
    endtask

    task automatic test_default_spans();
        send_sample(SAMPLE_MAX, 1'b0);
        send_sample('0, 1'b1);
        send_sample('0, 1'b1);
        settle();
    endtask

    task automatic test_window_extremes();
        write_span(CFG_BEFORE_SPAN, '1);
        write_span(CFG_AFTER_SPAN, '1);
        send_sample(40, 1'b0);
        send_sample(30, 1'b0);
        send_sample(20, 1'b0);
        send_sample(10, 1'b0);
        send_sample(20, 1'b0);
        send_sample(30, 1'b0);
        send_sample(40, 1'b0);
        send_sample(50, 1'b0);
        send_sample(60, 1'b1);
        settle();
        write_span(CFG_AFTER_SPAN, '0);
        send_sample(5, 1'b0);
        send_sample(9, 1'b0);
        send_sample(3, 1'b1);
        settle();
    endtask

    task automatic test_ties_and_ignored();
        write_span(CFG_BEFORE_SPAN, 3'd2);
        write_span(CFG_AFTER_SPAN, 3'd2);
        repeat (3) send_sample(6, 1'b0);
        send_sample(6, 1'b1);
        settle();
        write_span(CFG_BEFORE_SPAN, '0);
        write_span(CFG_AFTER_SPAN, 3'd1);
        send_sample(9, 1'b0);
        send_sample(4, 1'b0);
        send_sample(7, 1'b0);
        send_sample(1, 1'b0);
        send_sample(8, 1'b1);
        settle();
    endtask

    // unmapped index must leave both spans alone
    task automatic test_unused_register();
        write_span(CFG_UNUSED, '1);
        send_sample(2, 1'b0);
        send_sample(1, 1'b1);
        settle();
    endtask

    task automatic test_backpressure();
        write_span(CFG_BEFORE_SPAN, '0);
        write_span(CFG_AFTER_SPAN, '0);
        idle_on = 1'b0;
        hold_request = LONG_HOLD;
        repeat (40) send_sample(SW'($urandom), 1'b1);
        settle();
        idle_on = 1'b1;
    endtask

    // long falling run, resolved at its last sample
    task automatic test_long_run();
        write_span(CFG_BEFORE_SPAN, '0);
        write_span(CFG_AFTER_SPAN, 3'd1);
        idle_on = 1'b0;
        for (int n = 0; n < LONG_RUN; n++) begin
            send_sample(SAMPLE_MAX - SW'(n), n == LONG_RUN - 1);
        end
        settle();
        idle_on = 1'b1;
    endtask

    task automatic test_random_runs();
        int phase;
        int start;
        int len;
        phase = 0;
        start = samples_sent;
        while (samples_sent - start < RANDOM_SAMPLES) begin
            write_span(CFG_BEFORE_SPAN, pick_span());
            write_span(CFG_AFTER_SPAN, pick_span());
            idle_on = (phase % 4 != 3);
            repeat (12) begin
                len = ($urandom_range(0, 19) == 0) ? $urandom_range(25, 200)
                                                   : $urandom_range(1, 24);
                send_run(len, t_run_shape'($urandom_range(0, 4)));
            end
            settle();
            phase++;
        end
        idle_on = 1'b1;
    endtask

    initial begin : main
        i_rst_n      = 1'b0;
        i_cfg_valid  = 1'b0;
        i_cfg_index  = CFG_BEFORE_SPAN;
        i_cfg_data   = '0;
        i_in_valid   = 1'b0;
        i_sample     = '0;
        i_last       = 1'b0;
        span_before  = '0;
        span_after   = '0;
        fail_count   = 0;
        samples_sent = 0;
        live_samples = 0;
        runs_sent    = 0;
        positions_checked = 0;
        quiet_cycles = 0;
        hold_request = 0;
        idle_on      = 1'b1;
        clear_run();
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_default_spans();
        test_window_extremes();
        test_ties_and_ignored();
        test_unused_register();
        test_backpressure();
        test_long_run();
        test_random_runs();

        settle();
        repeat (8) @(posedge i_clk);
        if (expected_positions.size() != 0) begin
            $error("position: expected %0d more, got none", expected_positions.size());
            fail_count++;
        end
        $display("covered %0d samples (%0d evaluated) in %0d runs, %0d positions checked",
                 samples_sent, live_samples, runs_sent, positions_checked);
        $display("spans 0..7, ties, ignored tails, output hold-off, long falling run");
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule

### filelist.f
+incdir+rtl
rtl/wlmf_pkg.sv
rtl/wlmf_cell.sv
rtl/windowed_local_minimum_finder.sv
tb/tb.sv
